@@ hdl/hslp_pkg.sv @@
// ----------------------------------------------------------------------------
// hslp_pkg
// shared types and constants for the hashed slot linear probe insert unit
// ----------------------------------------------------------------------------
package hslp_pkg;

    localparam int unsigned TableSlots = 4096;
    localparam int unsigned ProbeLimit = 1024;
    localparam int unsigned SlotW      = $clog2(TableSlots);
    localparam int unsigned CountW     = SlotW + 1;
    localparam int unsigned ProbeW     = $clog2(ProbeLimit) + 1;
    localparam logic [63:0] HashMul    = 64'hff51afd7ed558ccd;
    localparam int unsigned HashShift  = 33;
    localparam int unsigned CfgIdxW    = 1;
    localparam int unsigned CfgDataW   = 13;

    localparam logic [CfgIdxW-1:0] CfgSlotCount    = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgWriteProtect = 1'b1;

    typedef enum logic [1:0] {
        ST_WRITTEN   = 2'd0,
        ST_FULL      = 2'd1,
        ST_PROTECTED = 2'd2,
        ST_NO_SLOTS  = 2'd3
    } t_status;

    // input beat
    typedef struct packed {
        logic [63:0] ident_low;
        logic [63:0] ident_high;
        logic [63:0] entry_class;
    } t_insert;

    // result beat
    typedef struct packed {
        t_status          status;
        logic [SlotW-1:0] slot_index;
        logic             was_update;
    } t_answer;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIX, S_MUL, S_MUL_HL, S_MUL_LH, S_MIX2, S_MOD, S_READ,
        S_CHECK, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr_write;   // write zero at sweep address
        logic clr_step;
        logic load;        // capture input item
        logic mix;
        logic mul;
        logic mul_hl;
        logic mul_lh;
        logic mix2;
        logic mod_init;
        logic mod_step;
        logic rd;
        logic advance;
        logic wr;
        logic res_load;
        t_status res_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic hit;
        logic probe_last;
    } t_stat;

endpackage

@@ hdl/hslp_if.sv @@
// ----------------------------------------------------------------------------
// hslp_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface hslp_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/hslp_ctrl.sv @@
// ----------------------------------------------------------------------------
// hslp_ctrl
// sequencer for clear sweep, hash, reduction and probe loop
// ----------------------------------------------------------------------------
module hslp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_busy,
    input  logic            i_wp,
    input  logic            i_zero,
    input  hslp_pkg::t_stat i_stat,
    output hslp_pkg::t_cmd  o_cmd
);
    import hslp_pkg::*;

    t_state r_state, n_state;
    logic   take;

    // quick answers need the result register free at once
    assign take = i_in_valid && !(i_out_busy && (i_wp || i_zero));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (take) begin
                    n_state = (i_wp || i_zero) ? S_IDLE : S_MIX;
                end
            end
            S_MIX:    n_state = S_MUL;
            S_MUL:    n_state = S_MUL_HL;
            S_MUL_HL: n_state = S_MUL_LH;
            S_MUL_LH: n_state = S_MIX2;
            S_MIX2:   n_state = S_MOD;
            S_MOD:    if (i_stat.mod_done) n_state = S_READ;
            S_READ:   n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.hit || i_stat.probe_last) begin
                    if (!i_out_busy) n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = ST_WRITTEN;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                o_cmd.clr_step  = 1'b1;
            end
            S_IDLE: begin
                o_in_ready = !(i_out_busy && (i_wp || i_zero));
                if (take) begin
                    o_cmd.load = 1'b1;
                    if (i_wp) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_PROTECTED;
                    end else if (i_zero) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_NO_SLOTS;
                    end
                end
            end
            S_MIX:    o_cmd.mix = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_MUL_HL: o_cmd.mul_hl = 1'b1;
            S_MUL_LH: o_cmd.mul_lh = 1'b1;
            S_MIX2: begin
                o_cmd.mix2     = 1'b1;
                o_cmd.mod_init = 1'b1;
            end
            S_MOD:  o_cmd.mod_step = 1'b1;
            S_READ: o_cmd.rd = 1'b1;
            S_CHECK: begin
                // a finished probe waits here until the result register is free
                if (!i_stat.hit && !i_stat.probe_last) begin
                    o_cmd.advance = 1'b1;
                end else if (!i_out_busy) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.hit) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.res_status = ST_FULL;
                    end
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end
endmodule

@@ hdl/hslp_dp.sv @@
// ----------------------------------------------------------------------------
// hslp_dp
// hash datapath, restoring modulo unit, slot store and result register
// ----------------------------------------------------------------------------
module hslp_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hslp_pkg::t_cmd             i_cmd,
    output hslp_pkg::t_stat            o_stat,
    input  logic [63:0]                i_lo,
    input  logic [63:0]                i_hi,
    input  logic [63:0]                i_cls,
    input  logic [hslp_pkg::SlotW:0]   i_count,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output hslp_pkg::t_status          o_status,
    output logic [hslp_pkg::SlotW-1:0] o_slot,
    output logic                       o_upd
);
    import hslp_pkg::*;

    logic [63:0]       mem_lo [TableSlots];
    logic [63:0]       mem_hi [TableSlots];
    logic              mem_c  [TableSlots];

    logic [63:0]       r_lo, r_hi, r_h;
    logic [63:0]       r_acc;
    logic              r_cls;
    logic [CountW-1:0] r_cnt;
    logic [SlotW-1:0]  r_clr;
    logic [CountW-1:0] r_rem;
    logic [6:0]        r_bit;
    logic [SlotW-1:0]  r_cur;
    logic [ProbeW-1:0] r_probes;
    logic [63:0]       r_rd_lo, r_rd_hi;
    logic              r_rd_c;
    logic              r_ov;
    t_status           r_status;
    logic [SlotW-1:0]  r_slot;
    logic              r_upd;

    logic              empty, same;
    logic [5:0]        bit_idx;
    logic [CountW:0]   rem_sh;
    logic [SlotW-1:0]  wr_addr;
    logic [SlotW:0]    cur_inc;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;

    assign empty   = (r_rd_lo == '0) && (r_rd_hi == '0) && !r_rd_c;
    assign same    = (r_rd_lo == r_lo) && (r_rd_hi == r_hi);
    // r_bit counts 64..1, the hash bit taken is r_bit-1
    assign bit_idx = 6'(r_bit - 7'd1);
    assign rem_sh  = {r_rem, r_h[bit_idx]};
    assign wr_addr = i_cmd.clr_write ? r_clr : r_cur;
    assign cur_inc = {1'b0, r_cur} + 1'b1;

    // low 64 bits of the product from three 32x32 partial products
    assign mul_a = i_cmd.mul_lh ? r_h[63:32] : r_h[31:0];
    assign mul_b = i_cmd.mul_hl ? HashMul[63:32] : HashMul[31:0];
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    assign o_stat.clr_last   = (r_clr == SlotW'(TableSlots - 1));
    assign o_stat.mod_done   = (r_bit == '0);
    assign o_stat.hit        = empty || same;
    assign o_stat.probe_last = (r_probes == ProbeW'(ProbeLimit - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_write || i_cmd.wr) begin
            mem_lo[wr_addr] <= i_cmd.clr_write ? '0 : r_lo;
            mem_hi[wr_addr] <= i_cmd.clr_write ? '0 : r_hi;
            mem_c[wr_addr]  <= i_cmd.clr_write ? 1'b0 : r_cls;
        end
        if (i_cmd.rd) begin
            r_rd_lo <= mem_lo[r_cur];
            r_rd_hi <= mem_hi[r_cur];
            r_rd_c  <= mem_c[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lo  <= i_lo;
            r_hi  <= i_hi;
            r_cls <= (i_cls != '0);
            r_h   <= i_lo ^ i_hi;
            r_cnt <= (i_count > CountW'(TableSlots)) ? CountW'(TableSlots) : i_count;
        end
        if (i_cmd.mix)    r_h <= r_h ^ (r_h >> HashShift);
        if (i_cmd.mul)    r_acc <= mul_p;
        if (i_cmd.mul_hl) r_acc <= r_acc + {mul_p[31:0], 32'd0};
        if (i_cmd.mul_lh) r_h <= r_acc + {mul_p[31:0], 32'd0};
        if (i_cmd.mix2)   r_h <= r_h ^ (r_h >> HashShift);
        if (i_cmd.mod_init) begin
            r_rem    <= '0;
            r_bit    <= 7'd64;
            r_probes <= '0;
        end
        // restoring remainder, one hash bit a beat, msb first
        if (i_cmd.mod_step && r_bit != '0) begin
            if (rem_sh >= {1'b0, r_cnt}) r_rem <= CountW'(rem_sh - {1'b0, r_cnt});
            else r_rem <= rem_sh[CountW-1:0];
            r_bit <= r_bit - 1'b1;
        end
        if (i_cmd.mod_step && r_bit == '0) r_cur <= r_rem[SlotW-1:0];
        if (i_cmd.advance) begin
            r_cur    <= (cur_inc >= r_cnt) ? '0 : cur_inc[SlotW-1:0];
            r_probes <= r_probes + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_slot   <= (i_cmd.res_status == ST_WRITTEN) ? r_cur : '0;
            r_upd    <= (i_cmd.res_status == ST_WRITTEN) && same && !empty;
        end
    end

    assign o_out_valid = r_ov;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_upd       = r_upd;
endmodule

@@ hdl/hashed_slot_linear_probe_insert_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_slot_linear_probe_insert_unit
// open-addressing slot table insert with hashed home slot and linear probe
// ----------------------------------------------------------------------------
// channel  dir  payload
// in       in   ident_low, ident_high, entry_class
// out      out  status, slot_index, was_update
// cfg      in   write enable, index, data
//
// an insert runs the hash steps (mix, the split multiply over three partial
// products, a second mix), the msb-first remainder steps, a read and a
// compare per probed slot and a closing state.
// protected or zero-slot inserts are answered in the cycle after they are
// taken. after reset a clearing pass zeroes the whole slot store; no beat is
// taken meanwhile. while an earlier result is not taken, a probed insert holds
// its last compare beat and a protected or zero-slot beat is not taken.
module hashed_slot_linear_probe_insert_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hslp_if.sink                            in_ch,
    hslp_if.source                          out_ch,
    input  logic                            i_cfg_we,
    input  logic [hslp_pkg::CfgIdxW-1:0]    i_cfg_idx,
    input  logic [hslp_pkg::CfgDataW-1:0]   i_cfg_data
);
    import hslp_pkg::*;

    logic [CountW-1:0] r_slot_count;
    logic              r_wp;
    t_cmd              cmd;
    t_stat             stat;
    t_status           status;
    logic [SlotW-1:0]  slot;
    logic              upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CountW'(TableSlots);
            r_wp         <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgSlotCount:    r_slot_count <= i_cfg_data[CountW-1:0];
                CfgWriteProtect: r_wp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    hslp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_out_busy (out_ch.valid),
        .i_wp       (r_wp),
        .i_zero     (r_slot_count == '0),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hslp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_lo        (in_ch.data.ident_low),
        .i_hi        (in_ch.data.ident_high),
        .i_cls       (in_ch.data.entry_class),
        .i_count     (r_slot_count),
        .i_out_ready (out_ch.ready),
        .o_out_valid (out_ch.valid),
        .o_status    (status),
        .o_slot      (slot),
        .o_upd       (upd)
    );

    assign out_ch.data.status     = status;
    assign out_ch.data.slot_index = slot;
    assign out_ch.data.was_update = upd;
endmodule

@@ bench/hashed_slot_linear_probe_insert_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_slot_linear_probe_insert_unit_test
// self-checking bench: inserts records through the valid/ready channel,
// keeps its own copy of the slot table and predicts status, slot and update
// flag of every insert, across several table sizes and the protect switch
// ----------------------------------------------------------------------------
module hashed_slot_linear_probe_insert_unit_test;
    import hslp_pkg::*;

    localparam int unsigned CycleLimit = 6_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    hslp_if #(.T(t_insert)) ins_ch ();
    hslp_if #(.T(t_answer)) ans_ch ();

    hashed_slot_linear_probe_insert_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (ins_ch.sink),
        .out_ch     (ans_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // table copy
    logic [63:0] tbl_low  [TableSlots];
    logic [63:0] tbl_high [TableSlots];
    logic        tbl_cls  [TableSlots];
    logic [12:0] cur_count;
    logic        cur_protect;

    t_answer     pending_answers[$];
    logic [63:0] ident_pool_low[32];
    logic [63:0] ident_pool_high[32];
    int          errors;
    int          status_seen[4];
    int          inserts_sent;
    int          updates_seen;
    int          rx_hold;
    int          rx_gap;
    bit          steady;
    longint      cycles;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("hashed_slot_linear_probe_insert_unit: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 80);
    endfunction

    // receiver side: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ans_ch.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            ans_ch.ready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else if (rx_gap > 0) begin
            ans_ch.ready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else begin
            ans_ch.ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) rx_gap = pick_gap();
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && ans_ch.valid && ans_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $error("result beat with nothing expected: %p", ans_ch.data);
                errors++;
            end else begin
                want = pending_answers.pop_front();
                if (ans_ch.data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, ans_ch.data.status);
                    errors++;
                end
                if (ans_ch.data.slot_index !== want.slot_index) begin
                    $error("slot_index: expected %0d, got %0d",
                           want.slot_index, ans_ch.data.slot_index);
                    errors++;
                end
                if (ans_ch.data.was_update !== want.was_update) begin
                    $error("was_update: expected %0d, got %0d",
                           want.was_update, ans_ch.data.was_update);
                    errors++;
                end
                status_seen[want.status]++;
                if (want.was_update) updates_seen++;
            end
        end
    end

    function automatic logic [63:0] ident_hash(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] h;
        h = lo ^ hi;
        h = h ^ (h >> HashShift);
        h = h * HashMul;
        h = h ^ (h >> HashShift);
        return h;
    endfunction

    // applies one insert to the table copy and returns the answer it gives
    function automatic t_answer insert_record(t_insert rec);
        t_answer     ans;
        longint unsigned cnt;
        longint unsigned pos;
        logic        empty;
        logic        same;
        ans = '{status: ST_WRITTEN, slot_index: '0, was_update: 1'b0};
        if (cur_protect) begin
            ans.status = ST_PROTECTED;
            return ans;
        end
        if (cur_count == 0) begin
            ans.status = ST_NO_SLOTS;
            return ans;
        end
        cnt = (cur_count > TableSlots) ? TableSlots : cur_count;
        pos = ident_hash(rec.ident_low, rec.ident_high) % cnt;
        for (int i = 0; i < ProbeLimit; i++) begin
            empty = tbl_low[pos] == 0 && tbl_high[pos] == 0 && !tbl_cls[pos];
            same  = tbl_low[pos] == rec.ident_low && tbl_high[pos] == rec.ident_high;
            if (empty || same) begin
                tbl_low[pos]   = rec.ident_low;
                tbl_high[pos]  = rec.ident_high;
                tbl_cls[pos]   = rec.entry_class != 0;
                ans.slot_index = pos[11:0];
                ans.was_update = same && !empty;
                return ans;
            end
            pos++;
            if (pos >= cnt) pos = 0;
        end
        ans.status = ST_FULL;
        return ans;
    endfunction

    task automatic send_insert(logic [63:0] lo, logic [63:0] hi, logic [63:0] cls);
        int     gap;
        t_insert rec;
        rec = '{ident_low: lo, ident_high: hi, entry_class: cls};
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            ins_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ins_ch.valid <= 1'b1;
        ins_ch.data  <= rec;
        @(posedge i_clk);
        while (!ins_ch.ready) @(posedge i_clk);
        pending_answers.push_back(insert_record(rec));
        inserts_sent++;
    endtask

    task automatic wait_all_answers();
        ins_ch.valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
        wait_all_answers();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgSlotCount) cur_count = value;
        else cur_protect = value[0];
    endtask

    task automatic setup(logic [12:0] count, logic protect);
        write_reg(CfgSlotCount, count);
        write_reg(CfgWriteProtect, {12'd0, protect});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_extremes();
        send_insert('1, '1, '1);
        send_insert('1, '1, '0);             // same identity: update
        send_insert(64'd1, 64'h8000_0000_0000_0000, 64'd1);
        send_insert(64'h1234_5678_9abc_def0, 64'h1234_5678_9abc_def0, 64'd5);
        send_insert(rand64(), rand64(), 64'h8000_0000_0000_0000);
    endtask

    // zero identity stops at an empty slot or at a zero-identity slot
    task automatic test_zero_identity();
        send_insert('0, '0, '0);
        send_insert('0, '0, 64'd1);
        send_insert('0, '0, 64'd2);
        send_insert('0, '0, '0);
        send_insert('0, '0, '0);
    endtask

    task automatic test_protect_and_zero_slots();
        setup(13'd4096, 1'b1);
        send_insert(rand64(), rand64(), 64'd3);
        write_reg(CfgSlotCount, 13'd0);      // protect still wins
        send_insert(rand64(), rand64(), 64'd3);
        write_reg(CfgWriteProtect, 13'd0);
        send_insert(rand64(), rand64(), 64'd3);
        send_insert('0, '0, '0);
    endtask

    task automatic test_oversized_count();
        setup(13'h1fff, 1'b0);
        send_insert(rand64(), rand64(), 64'd9);
        send_insert('1, '1, 64'd7);
        write_reg(CfgSlotCount, 13'd4097);
        send_insert(rand64(), rand64(), 64'd9);
    endtask

    // tiny table fills up, later inserts wrap and report full
    task automatic test_full_table();
        setup(13'd3, 1'b0);
        for (int i = 0; i < 5; i++) send_insert(rand64(), rand64(), 64'd1 + i);
        send_insert('1, '1, 64'd4);          // may hit an existing identity
        setup(13'd4096, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        steady = 1'b1;
        wait_all_answers();
        rx_hold = 700;
        for (int i = 0; i < 6; i++) send_insert(rand64(), rand64(), rand64());
        steady = 1'b0;
        wait_all_answers();
    endtask

    task automatic random_inserts(int n);
        int          r;
        int          k;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] cls;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 31);
            if (r < 40) begin
                lo = ident_pool_low[k];
                hi = ident_pool_high[k];
            end else if (r < 48) begin
                lo = '0;
                hi = '0;
            end else if (r < 56) begin
                lo = 64'd1 << $urandom_range(0, 63);
                hi = ($urandom_range(0, 1) == 1) ? (64'd1 << $urandom_range(0, 63)) : '0;
            end else begin
                lo = rand64();
                hi = rand64();
            end
            cls = ($urandom_range(0, 4) == 0) ? '0 : rand64();
            if (i % 60 == 30) steady = ~steady;  // stretches with no idling
            send_insert(lo, hi, cls);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_phases();
        logic [12:0] counts[9];
        logic        prot[9];
        int          lens[9];
        counts = '{13'd4096, 13'd7, 13'd1, 13'h1fff, 13'd100, 13'd0, 13'd4096, 13'd2000, 13'd0};
        prot   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        lens   = '{120, 30, 20, 70, 70, 15, 15, 120, 45};
        counts[8] = 13'($urandom_range(1, 4096));
        for (int p = 0; p < 9; p++) begin
            setup(counts[p], prot[p]);
            random_inserts(lens[p]);
        end
    endtask

    initial begin
        errors         = 0;
        inserts_sent   = 0;
        updates_seen   = 0;
        rx_hold        = 0;
        rx_gap         = 0;
        steady         = 1'b0;
        cycles         = 0;
        status_seen    = '{0, 0, 0, 0};
        cur_count      = 13'd4096;
        cur_protect    = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        ins_ch.valid   = 1'b0;
        ins_ch.data    = '0;
        for (int s = 0; s < TableSlots; s++) begin
            tbl_low[s]  = '0;
            tbl_high[s] = '0;
            tbl_cls[s]  = 1'b0;
        end
        for (int k = 0; k < 32; k++) begin
            ident_pool_low[k]  = rand64();
            ident_pool_high[k] = (k < 4) ? '0 : rand64();
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_zero_identity();
        test_protect_and_zero_slots();
        test_oversized_count();
        test_full_table();
        test_backpressure();
        test_random_phases();

        wait_all_answers();
        repeat (50) @(posedge i_clk);
        $display("%0d inserts: %0d written (%0d updates), %0d full, %0d protected, %0d no slots",
                 inserts_sent, status_seen[ST_WRITTEN], updates_seen, status_seen[ST_FULL],
                 status_seen[ST_PROTECTED], status_seen[ST_NO_SLOTS]);
        $display("table sizes 0 to 8191 incl. saturation, protect on and off, long stalls");
        if (errors == 0 && pending_answers.size() == 0) begin
            $display("hashed_slot_linear_probe_insert_unit: match");
        end else begin
            $display("hashed_slot_linear_probe_insert_unit: mismatch");
        end
        $finish;
    end

endmodule
